/* hw/rtl/interval_timer_three_channel_unit_defines.svh */
// assertion macros for the interval timer
`ifndef INTERVAL_TIMER_THREE_CHANNEL_UNIT_DEFINES_SVH
`define INTERVAL_TIMER_THREE_CHANNEL_UNIT_DEFINES_SVH

// property must hold at every edge outside reset
`define ITT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property must hold at every edge, reset included
`define ITT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/itt_pkg.sv */
`default_nettype none
package itt_pkg;

  localparam int unsigned NumChannelsDefault = 3;
  localparam int unsigned FifoDepth          = 2;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [2:0] PORT_CMD     = 3'd3;
  localparam logic [2:0] PORT_SPEAKER = 3'd4;

  localparam logic [1:0] AM_LATCH = 2'd0;
  localparam logic [1:0] AM_HIGH  = 2'd2;
  localparam logic [1:0] AM_BOTH  = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  localparam logic [1:0] RUN_PEND = 2'd1;
  localparam logic [1:0] RUN_GO   = 2'd2;

  localparam logic [2:0] OP_MODE0 = 3'd0;
  localparam logic [2:0] OP_MODE1 = 3'd1;
  localparam logic [2:0] OP_MODE2 = 3'd2;
  localparam logic [2:0] OP_MODE3 = 3'd3;
  localparam logic [2:0] OP_MODE4 = 3'd4;
  localparam logic [2:0] OP_MODE5 = 3'd5;

  // classified request from the front end
  typedef enum logic [3:0] {
    KIND_NONE  = 4'b0001,
    KIND_READ  = 4'b0010,
    KIND_WRITE = 4'b0100,
    KIND_TICK  = 4'b1000
  } req_kind_t;

  typedef struct packed {
    req_kind_t  kind;
    logic       bad;
    logic [2:0] port;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_raise;
    logic       error;
  } rsp_t;

endpackage
`default_nettype wire

/* hw/rtl/itt_front.sv */
`default_nettype none
module itt_front
  import itt_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] req_type,
  input  wire logic [2:0] port,
  input  wire logic [7:0] write_data,
  input  wire logic [2:0] access_bytes,
  output req_t            q_head,
  output logic            q_valid,
  input  wire logic       q_take
);

  localparam int unsigned PtrW = $clog2(FifoDepth);

  req_t            mem [FifoDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  req_t            cls;
  logic            do_push;
  logic            do_pop;
  logic            chan_port;

  // port is a channel that exists
  assign chan_port = (port < 3'd3) && ({29'd0, port} < NUM_CHANNELS);

  // classify the request
  always_comb begin
    cls.port = port;
    cls.data = write_data;
    cls.bad  = 1'b0;
    cls.kind = KIND_NONE;
    if (req_type == REQ_TICK) begin
      cls.kind = KIND_TICK;
    end else if (req_type == REQ_READ || req_type == REQ_WRITE) begin
      if (access_bytes != 3'd1) begin
        cls.bad = 1'b1;
      end else if (req_type == REQ_READ) begin
        cls.kind = KIND_READ;
        cls.bad  = !(chan_port || port == PORT_SPEAKER);
      end else begin
        cls.kind = KIND_WRITE;
        cls.bad  = !(chan_port || port == PORT_CMD || port == PORT_SPEAKER);
      end
    end else begin
      cls.bad = 1'b1;
    end
  end

  assign full    = (count == (PtrW+1)'(FifoDepth));
  assign q_valid = (count != '0);
  assign q_head  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  // request queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/itt_back.sv */
`default_nettype none
`include "interval_timer_three_channel_unit_defines.svh"
module itt_back
  import itt_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire req_t        q_head,
  input  wire logic        q_valid,
  output logic             q_take,
  output rsp_t             rsp,
  output logic             rsp_valid,
  input  wire logic        rsp_take
);

  logic [15:0] divider;
  logic [15:0] prescale_count;
  logic [15:0] counter   [3];
  logic [15:0] reload    [3];
  logic [15:0] latched   [3];
  logic [1:0]  acc_mode  [3];
  logic [1:0]  acc_phase [3];
  logic [1:0]  run_phase [3];
  logic [2:0]  op_mode   [3];
  logic        latch_flag[3];
  logic        read_high [3];
  logic        out_pin   [3];
  logic [7:0]  speaker_reg;

  logic [15:0] counter_next   [3];
  logic [15:0] reload_next    [3];
  logic [15:0] latched_next   [3];
  logic [1:0]  acc_mode_next  [3];
  logic [1:0]  acc_phase_next [3];
  logic [1:0]  run_phase_next [3];
  logic [2:0]  op_mode_next   [3];
  logic        latch_flag_next[3];
  logic        read_high_next [3];
  logic        out_pin_next   [3];
  logic [7:0]  speaker_next;
  logic [15:0] prescale_next;
  rsp_t        rsp_next;
  logic        fire;

  // output register slot: free or draining this cycle
  assign q_take = q_valid && (!rsp_valid || rsp_take);
  assign fire   = q_take;

  // oscillation on one channel; returns state pieces and signal/error
  function automatic logic [20:0] osc_step(
    input logic [15:0] cnt, input logic [15:0] rel, input logic [1:0] rp,
    input logic [2:0] op, input logic pin);
    logic [15:0] c;
    logic [1:0]  osc;
    logic [15:0] rv;
    logic        p;
    logic        sig;
    logic        er;
    c   = cnt;
    osc = 2'd1;
    p   = pin;
    sig = 1'b0;
    er  = 1'b0;
    rv  = 16'hffff;
    if (rp == RUN_PEND) begin
      osc = 2'd0;
      c   = (op == OP_MODE3) ? (rel & 16'hfffe) : rel;
    end
    if (op == OP_MODE3) begin
      osc = {osc[0], 1'b0};
    end
    if (rp != RUN_PEND && rp != RUN_GO) begin
      c = cnt;
    end else if ({14'd0, osc} < c) begin
      c = c - {14'd0, osc};
    end else begin
      rv = (op == OP_MODE4 || op == OP_MODE0) ? 16'hffff : rel;
      if (op == OP_MODE3) begin
        rv = rv & 16'hfffe;
      end
      if (rv == 16'd0) begin
        rv = 16'hffff;
      end
      // remaining osc is 0..2 and below rv except rv of 1 or 2
      osc = osc - c[1:0];
      if ({14'd0, osc} >= rv) begin
        osc = osc - rv[1:0];
      end
      c = rv - {14'd0, osc};
      case (op)
        OP_MODE0, OP_MODE1: begin
          if (!p) begin
            p   = 1'b1;
            sig = 1'b1;
          end
        end
        OP_MODE2: sig = 1'b1;
        OP_MODE3: begin
          p   = !p;
          sig = p;
        end
        OP_MODE4: begin
          if (p) begin
            p   = 1'b0;
            sig = 1'b1;
          end
        end
        OP_MODE5: er = 1'b1;
        default: sig = 1'b0;
      endcase
    end
    return {c, (rp == RUN_PEND) ? RUN_GO : rp, p, sig, er};
  endfunction

  // execute one request
  always_comb begin
    logic [20:0] r0;
    logic [20:0] r2;
    logic [1:0]  ch;
    logic [2:0]  op;
    logic [1:0]  am;
    logic        restart;
    logic [15:0] v;
    logic        set_ok;
    logic [2:0]  pin_op;
    for (int i = 0; i < 3; i++) begin
      counter_next[i]    = counter[i];
      reload_next[i]     = reload[i];
      latched_next[i]    = latched[i];
      acc_mode_next[i]   = acc_mode[i];
      acc_phase_next[i]  = acc_phase[i];
      run_phase_next[i]  = run_phase[i];
      op_mode_next[i]    = op_mode[i];
      latch_flag_next[i] = latch_flag[i];
      read_high_next[i]  = read_high[i];
      out_pin_next[i]    = out_pin[i];
    end
    speaker_next  = speaker_reg;
    prescale_next = prescale_count;
    rsp_next      = '0;
    r0      = '0;
    r2      = '0;
    ch      = q_head.port[1:0];
    op      = q_head.data[3:1];
    am      = q_head.data[5:4];
    restart = 1'b0;
    v       = '0;
    set_ok  = 1'b0;
    pin_op  = '0;
    if (q_head.bad) begin
      rsp_next.error = 1'b1;
    end else begin
      case (q_head.kind)
        KIND_TICK: begin
          if (prescale_count > 16'd1) begin
            prescale_next = prescale_count - 16'd1;
          end else begin
            prescale_next = (prescale_count == 16'd1) ?
                            ((divider == '0) ? 16'd1 : divider) :
                            ((divider == '0) ? 16'd0 : divider - 16'd1);
            r0 = osc_step(counter[0], reload[0], run_phase[0], op_mode[0], out_pin[0]);
            counter_next[0]   = r0[20:5];
            run_phase_next[0] = r0[4:3];
            out_pin_next[0]   = r0[2];
            rsp_next.irq_raise = r0[1];
            rsp_next.error     = r0[0];
            if (NUM_CHANNELS > 2) begin
              r2 = osc_step(counter[2], reload[2], run_phase[2], op_mode[2], out_pin[2]);
              counter_next[2]   = r2[20:5];
              run_phase_next[2] = r2[4:3];
              out_pin_next[2]   = r2[2];
              rsp_next.error    = r0[0] | r2[0];
            end
          end
        end
        KIND_READ: begin
          if (q_head.port == PORT_SPEAKER) begin
            rsp_next.read_data = speaker_reg;
            if (speaker_reg[0] && NUM_CHANNELS > 2) begin
              rsp_next.read_data[5] = speaker_reg[5] | out_pin[2];
            end
          end else begin
            v = latch_flag[ch] ? latched[ch] : counter[ch];
            if (!read_high[ch]) begin
              read_high_next[ch] = 1'b1;
              rsp_next.read_data = v[7:0];
            end else begin
              read_high_next[ch]  = 1'b0;
              latch_flag_next[ch] = 1'b0;
              rsp_next.read_data  = v[15:8];
            end
          end
        end
        KIND_WRITE: begin
          if (q_head.port == PORT_SPEAKER) begin
            speaker_next = q_head.data & 8'hdf;
          end else if (q_head.port == PORT_CMD) begin
            ch = q_head.data[7:6];
            if ({30'd0, ch} >= NUM_CHANNELS || ch == 2'd3) begin
              rsp_next.error = 1'b1;
            end else begin
              if (am != AM_LATCH) begin
                op_mode_next[ch] = op;
              end
              acc_mode_next[ch] = am;
              if (am == AM_LATCH) begin
                if (!latch_flag[ch]) begin
                  latched_next[ch]    = counter[ch];
                  latch_flag_next[ch] = 1'b1;
                end
              end else if (am == AM_HIGH) begin
                acc_phase_next[ch] = PH_HIGH;
              end else begin
                acc_phase_next[ch] = PH_LOW;
              end
              set_ok = 1'b1;
              pin_op = op;
            end
          end else begin
            restart = (op_mode[ch] != OP_MODE2) || (run_phase[ch] != RUN_GO);
            if (acc_phase[ch] == PH_HIGH) begin
              reload_next[ch] = {q_head.data, reload[ch][7:0]};
              if (restart) begin
                run_phase_next[ch] = RUN_PEND;
              end
              if (acc_mode[ch] == AM_BOTH) begin
                acc_phase_next[ch] = PH_LOW;
              end
              set_ok = 1'b1;
            end else if (acc_phase[ch] == PH_LOW) begin
              reload_next[ch] = {reload[ch][15:8], q_head.data};
              if (acc_mode[ch] == AM_BOTH) begin
                acc_phase_next[ch] = PH_HIGH;
              end else if (restart) begin
                run_phase_next[ch] = RUN_PEND;
              end
              set_ok = 1'b1;
            end else begin
              rsp_next.error = 1'b1;
            end
            pin_op = op_mode[ch];
          end
          // pin level after programming
          if (set_ok) begin
            if (pin_op == OP_MODE0) begin
              out_pin_next[ch] = 1'b0;
            end else if (pin_op <= OP_MODE4) begin
              out_pin_next[ch] = 1'b1;
            end else begin
              rsp_next.error = 1'b1;
            end
          end
        end
        default: rsp_next.error = 1'b1;
      endcase
    end
  end

  // divider register
  always_ff @(posedge clk) begin
    if (rst) begin
      divider <= 16'd1;
    end else if (cfg_we) begin
      divider <= cfg_data;
    end
  end

  // timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      speaker_reg    <= '0;
      for (int i = 0; i < 3; i++) begin
        counter[i]    <= '0;
        reload[i]     <= '0;
        latched[i]    <= '0;
        acc_mode[i]   <= '0;
        acc_phase[i]  <= '0;
        run_phase[i]  <= '0;
        op_mode[i]    <= '0;
        latch_flag[i] <= 1'b0;
        read_high[i]  <= 1'b0;
        out_pin[i]    <= 1'b0;
      end
    end else if (fire) begin
      prescale_count <= prescale_next;
      speaker_reg    <= speaker_next;
      for (int i = 0; i < 3; i++) begin
        counter[i]    <= counter_next[i];
        reload[i]     <= reload_next[i];
        latched[i]    <= latched_next[i];
        acc_mode[i]   <= acc_mode_next[i];
        acc_phase[i]  <= acc_phase_next[i];
        run_phase[i]  <= run_phase_next[i];
        op_mode[i]    <= op_mode_next[i];
        latch_flag[i] <= latch_flag_next[i];
        read_high[i]  <= read_high_next[i];
        out_pin[i]    <= out_pin_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  `ITT_ASSERT(a_no_take_when_blocked, (rsp_valid && !rsp_take) |-> !q_take, "took request with result slot full")
  `ITT_ASSERT(a_fire_fills, fire |=> rsp_valid, "result not registered after request")
  `ITT_ASSERT(a_chan1_idle, q_take && q_head.kind == KIND_TICK |=> $stable(counter[1]), "channel 1 advanced on tick")
  `ITT_ASSERT_ALWAYS(a_reset_empty, rst |=> !rsp_valid, "result valid after reset")

endmodule
`default_nettype wire

/* hw/rtl/interval_timer_three_channel_unit.sv */
// Three-channel interval timer behind a request queue. Each request (port read,
// port write or one input clock tick) yields exactly one result. A request is
// taken whenever the queue is not full: the front end classifies it into a
// two-entry queue and the back end executes it into a result register, so the sustained rate
// is one request per clock while results are popped; the result register is the
// only thing that stalls the back end.
`default_nettype none
module interval_timer_three_channel_unit
  import itt_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [2:0]  port,
  input  wire logic [7:0]  write_data,
  input  wire logic [2:0]  access_bytes,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       read_data,
  output logic             irq_raise,
  output logic             error,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  req_t q_head;
  logic q_valid;
  logic q_take;
  rsp_t rsp;
  logic rsp_valid;

  // request classification and queue
  itt_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk, .rst, .push, .full, .req_type, .port, .write_data, .access_bytes,
    .q_head, .q_valid, .q_take
  );

  // timer execution
  itt_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk, .rst, .cfg_we, .cfg_data, .q_head, .q_valid, .q_take,
    .rsp, .rsp_valid, .rsp_take(pop)
  );

  assign empty     = !rsp_valid;
  assign read_data = rsp.read_data;
  assign irq_raise = rsp.irq_raise;
  assign error     = rsp.error;

endmodule
`default_nettype wire

/* sim/tb_interval_timer_three_channel_unit.sv */
`timescale 1ns / 1ps
module tb_interval_timer_three_channel_unit;
  import itt_pkg::*;

  localparam logic [1:0] REQ_BAD  = 2'd3;
  localparam logic [1:0] AM_LOW   = 2'd1;
  localparam logic [1:0] RUN_STOP = 2'd0;
  localparam logic [2:0] OP_MODE6 = 3'd6;
  localparam logic [2:0] OP_MODE7 = 3'd7;
  localparam int         NCH      = 3;

  // timer model plus queue of expected results
  class timer_scoreboard;
    bit [15:0] divider, prescale;
    bit [15:0] count[NCH], reload[NCH], latched[NCH];
    bit [1:0]  acc_mode[NCH], acc_phase[NCH], run[NCH];
    bit [2:0]  op[NCH];
    bit        latch_flag[NCH], read_high[NCH], pin[NCH];
    bit [7:0]  speaker;
    rsp_t      expected_rsp[$];
    int        mismatches;

    function new();
      divider = 16'd1;
      prescale = '0;
      for (int c = 0; c < NCH; c++) begin
        count[c] = '0; reload[c] = '0; latched[c] = '0;
        acc_mode[c] = AM_LATCH; acc_phase[c] = PH_IDLE; run[c] = RUN_STOP;
        op[c] = OP_MODE0; latch_flag[c] = 0; read_high[c] = 0; pin[c] = 0;
      end
      speaker = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // one oscillation; returns {error, signal}
    function bit [1:0] oscillate(int c);
      int unsigned o, rv;
      bit [2:0] m;
      o = 1;
      m = op[c];
      if (run[c] == RUN_PEND) begin
        o = 0;
        count[c] = reload[c];
        if (m == OP_MODE3) count[c] &= 16'hfffe;
        run[c] = RUN_GO;
      end else if (run[c] != RUN_GO) begin
        return 2'b00;
      end
      if (m == OP_MODE3) o = o * 2;
      if (count[c] > o) begin
        count[c] = count[c] - o;
        return 2'b00;
      end
      rv = reload[c];
      if (m == OP_MODE4 || m == OP_MODE0) rv = 16'hffff;
      o = o - count[c];
      if (m == OP_MODE3) rv &= 16'hfffe;
      if (rv == 0) rv = 16'hffff;
      o = o % rv;
      count[c] = rv - o;
      case (m)
        OP_MODE0, OP_MODE1: begin
          if (!pin[c]) begin
            pin[c] = 1;
            return 2'b01;
          end
          return 2'b00;
        end
        OP_MODE2: return 2'b01;
        OP_MODE3: begin
          pin[c] = ~pin[c];
          return {1'b0, pin[c]};
        end
        OP_MODE4: begin
          if (pin[c]) begin
            pin[c] = 0;
            return 2'b01;
          end
          return 2'b00;
        end
        OP_MODE5: return 2'b10;
        default: return 2'b00;
      endcase
    endfunction

    // pin after programming; returns 0 for modes 5..7
    function bit program_pin(int c, bit [2:0] m);
      if (m == OP_MODE0) begin
        pin[c] = 0;
        return 1;
      end
      if (m <= OP_MODE4) begin
        pin[c] = 1;
        return 1;
      end
      return 0;
    endfunction

    function bit write_data_byte(int c, bit [7:0] v);
      bit restart;
      restart = (op[c] != OP_MODE2) || (run[c] != RUN_GO);
      if (acc_phase[c] == PH_HIGH) begin
        reload[c] = {v, reload[c][7:0]};
        if (restart) run[c] = RUN_PEND;
        if (acc_mode[c] == AM_BOTH) acc_phase[c] = PH_LOW;
      end else if (acc_phase[c] == PH_LOW) begin
        reload[c] = {reload[c][15:8], v};
        if (acc_mode[c] == AM_BOTH) acc_phase[c] = PH_HIGH;
        else if (restart) run[c] = RUN_PEND;
      end else begin
        return 0;
      end
      return program_pin(c, op[c]);
    endfunction

    function bit write_command(bit [7:0] cmd);
      bit [2:0] m;
      bit [1:0] am;
      int c;
      m = cmd[3:1];
      am = cmd[5:4];
      c = cmd[7:6];
      if (c >= NCH) return 0;
      if (am != AM_LATCH) op[c] = m;
      acc_mode[c] = am;
      if (am == AM_LATCH) begin
        if (!latch_flag[c]) begin
          latched[c] = count[c];
          latch_flag[c] = 1;
        end
      end else if (am == AM_HIGH) begin
        acc_phase[c] = PH_HIGH;
      end else begin
        acc_phase[c] = PH_LOW;
      end
      return program_pin(c, m);
    endfunction

    function bit [7:0] read_data_byte(int c);
      bit [15:0] v;
      v = latch_flag[c] ? latched[c] : count[c];
      if (!read_high[c]) begin
        read_high[c] = 1;
        return v[7:0];
      end
      read_high[c] = 0;
      latch_flag[c] = 0;
      return v[15:8];
    endfunction

    // accepted request: advance the model, queue its result
    function void note_request(bit [1:0] t, bit [2:0] p, bit [7:0] d, bit [2:0] len);
      rsp_t r;
      bit [15:0] dv;
      bit [1:0] s0, s2;
      r = '0;
      if (t == REQ_TICK) begin
        dv = (divider != 0) ? divider : 16'd1;
        if (prescale > 1) begin
          prescale = prescale - 1;
        end else begin
          prescale = (prescale == 1) ? dv : dv - 16'd1;
          s0 = oscillate(0);
          s2 = oscillate(2);
          r.irq_raise = s0[0];
          r.error = s0[1] | s2[1];
        end
      end else if (t == REQ_BAD || len != 3'd1) begin
        r.error = 1;
      end else if (t == REQ_READ) begin
        if (p < NCH) r.read_data = read_data_byte(p);
        else if (p == PORT_SPEAKER) begin
          r.read_data = speaker;
          if (speaker[0]) r.read_data[5] = r.read_data[5] | pin[2];
        end else r.error = 1;
      end else begin
        if (p < NCH) r.error = !write_data_byte(p, d);
        else if (p == PORT_CMD) r.error = !write_command(d);
        else if (p == PORT_SPEAKER) speaker = d & ~8'h20;
        else r.error = 1;
      end
      expected_rsp.push_back(r);
    endfunction

    function void check_result(bit [7:0] rd, bit irq, bit err);
      rsp_t e;
      if (expected_rsp.size() == 0) begin
        $display("%0t unexpected result rd=%0h irq=%0b err=%0b", $time, rd, irq, err);
        mismatches++;
        return;
      end
      e = expected_rsp.pop_front();
      if (e.read_data != rd) begin
        $display("%0t read_data expected %0h actual %0h", $time, e.read_data, rd);
        mismatches++;
      end
      if (e.irq_raise != irq) begin
        $display("%0t irq_raise expected %0b actual %0b", $time, e.irq_raise, irq);
        mismatches++;
      end
      if (e.error != err) begin
        $display("%0t error expected %0b actual %0b", $time, e.error, err);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk, rst, push, pop, cfg_we;
  logic [1:0]  req_type;
  logic [2:0]  port, access_bytes;
  logic [7:0]  write_data;
  logic [15:0] cfg_data;
  wire         full, empty, irq_raise, error;
  wire  [7:0]  read_data;

  timer_scoreboard sb;
  int send_idle_pct, recv_stall_pct, hold_left;
  bit hold_req;

  interval_timer_three_channel_unit u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .port(port), .write_data(write_data), .access_bytes(access_bytes),
    .empty(empty), .pop(pop), .read_data(read_data), .irq_raise(irq_raise),
    .error(error), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  // result side: check accepted results, then pick next pop
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(read_data, irq_raise, error);
    if (hold_req && hold_left == 0) begin
      hold_left = 300;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one request, held until accepted
  task automatic send_req(bit [1:0] t, bit [2:0] p, bit [7:0] d, bit [2:0] len);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    req_type <= t;
    port <= p;
    write_data <= d;
    access_bytes <= len;
    do @(posedge clk); while (full);
    sb.note_request(t, p, d, len);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_divider(bit [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.divider = v;
  endtask

  // mostly well-formed timer traffic with small counts, some noise
  task automatic random_request();
    int k;
    bit [7:0] d;
    k = $urandom_range(99);
    d = ($urandom_range(9) < 7) ? 8'($urandom_range(9)) : 8'($urandom);
    if (k < 45) send_req(REQ_TICK, 3'($urandom), 8'($urandom), 3'd1);
    else if (k < 60) send_req(REQ_READ, 3'($urandom_range(2)), 8'($urandom), 3'd1);
    else if (k < 75) send_req(REQ_WRITE, ($urandom_range(9) == 0) ? 3'd1 : 3'(2 * $urandom_range(1)),
                              d, 3'd1);
    else if (k < 87) begin
      d = 8'($urandom);
      if ($urandom_range(19) != 0) d[7:6] = 2'($urandom_range(2));
      if ($urandom_range(9) != 0) d[3:1] = 3'($urandom_range(4));
      send_req(REQ_WRITE, PORT_CMD, d, 3'd1);
    end else if (k < 92) send_req(2'($urandom_range(1)), PORT_SPEAKER, 8'($urandom), 3'd1);
    else send_req(2'($urandom), 3'($urandom), 8'($urandom), 3'($urandom));
  endtask

  task automatic run_phase(bit [15:0] dv, int s_idle, int r_stall, int n, bit hold);
    set_divider(dv);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    if (hold) hold_req = 1;
    repeat (n) random_request();
  endtask

  initial begin
    rst = 1; push = 0; pop = 0; cfg_we = 0; cfg_data = '0;
    req_type = '0; port = '0; write_data = '0; access_bytes = 3'd1;
    send_idle_pct = 0; recv_stall_pct = 0; hold_left = 0; hold_req = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset state, modes 2, 3 and 5, each error path
    send_req(REQ_READ, 3'd0, 8'h00, 3'd1);
    send_req(REQ_WRITE, 3'd1, 8'hff, 3'd1);             // idle data write
    send_req(REQ_WRITE, PORT_CMD, 8'h34, 3'd1);         // ch0 mode 2 low/high
    send_req(REQ_WRITE, 3'd0, 8'h04, 3'd1);
    send_req(REQ_WRITE, 3'd0, 8'h00, 3'd1);
    send_req(REQ_WRITE, PORT_CMD, 8'hb6, 3'd1);         // ch2 square wave
    send_req(REQ_WRITE, 3'd2, 8'h05, 3'd1);
    send_req(REQ_WRITE, 3'd2, 8'h00, 3'd1);
    repeat (7) send_req(REQ_TICK, 3'd0, 8'h00, 3'd1);
    send_req(REQ_WRITE, PORT_SPEAKER, 8'hff, 3'd1);
    send_req(REQ_READ, PORT_SPEAKER, 8'h00, 3'd1);
    send_req(REQ_WRITE, PORT_CMD, 8'hc0, 3'd1);         // read-back
    send_req(REQ_WRITE, PORT_CMD, 8'h00, 3'd1);         // latch ch0
    send_req(REQ_READ, 3'd0, 8'h00, 3'd1);
    send_req(REQ_READ, 3'd0, 8'h00, 3'd1);
    send_req(REQ_WRITE, PORT_CMD, 8'h7c, 3'd1);         // ch1 mode 6
    send_req(REQ_READ, PORT_CMD, 8'h00, 3'd1);
    send_req(REQ_WRITE, 3'd7, 8'h00, 3'd1);
    send_req(REQ_READ, 3'd0, 8'h00, 3'd4);
    send_req(REQ_BAD, 3'd0, 8'h00, 3'd1);
    send_req(REQ_WRITE, PORT_CMD, 8'h1a, 3'd1);         // ch0 hardware strobe, low
    send_req(REQ_WRITE, 3'd0, 8'h01, 3'd1);
    repeat (3) send_req(REQ_TICK, 3'd0, 8'h00, 3'd1);

    run_phase(16'd1, 0, 0, 220, 0);
    run_phase(16'd3, 64, 0, 200, 0);
    run_phase(16'd1, 0, 64, 200, 1);
    run_phase(16'd65535, 17, 17, 150, 0);
    run_phase(16'd2, 17, 17, 230, 0);

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/itt_pkg.sv
hw/rtl/itt_front.sv
hw/rtl/itt_back.sv
hw/rtl/interval_timer_three_channel_unit.sv
sim/tb_interval_timer_three_channel_unit.sv
